### hdl/sad_pkg.sv
package sad_pkg;

    typedef enum logic [3:0] {
        KIND_APPEND     = 4'd0,
        KIND_DROP_BACK  = 4'd1,
        KIND_DROP_FRONT = 4'd2,
        KIND_SORT       = 4'd3,
        KIND_READ       = 4'd4,
        KIND_WRITE      = 4'd5,
        KIND_CLEAR      = 4'd6,
        KIND_SET_LENGTH = 4'd7,
        KIND_DUMP       = 4'd8
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_STREAM
    } t_state;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] value;
        logic [3:0]         position;
        logic [4:0]         new_length;
    } t_req;

    typedef struct packed {
        logic signed [31:0] element;
        logic [4:0]         length;
        t_status            status;
        logic               last;
    } t_res;

endpackage

### hdl/sad_mem.sv
module sad_mem #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic signed [31:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic signed [31:0] o_rdata
);

    logic signed [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hdl/sad_ctrl.sv
module sad_ctrl #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  sad_pkg::t_req      i_req,
    output logic               busy,
    output logic               o_strobe,
    output sad_pkg::t_res      o_res,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output logic signed [31:0] o_wdata,
    output logic [AW-1:0]      o_raddr,
    input  logic signed [31:0] i_rdata
);
    import sad_pkg::*;

    // common width for comparing the fixed-width fields against the count
    localparam int XW = (CW > 5) ? CW : 5;

    t_state             r_state, n_state;
    t_kind              r_op, n_op;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_rp, n_rp;
    logic               r_rv, n_rv;
    logic [AW-1:0]      r_ra, n_ra;
    logic signed [31:0] r_carry, n_carry;
    logic               r_swapped, n_swapped;
    logic               r_valid, n_valid;
    t_res               r_res, n_res;

    t_kind              kind_in;
    logic               issue;
    logic               stream_end;
    logic               in_range;
    logic               is_full;

    assign kind_in    = t_kind'(i_req.kind);
    assign issue      = (r_rp < r_count);
    assign stream_end = !issue && !r_rv;
    assign in_range   = XW'(i_req.position) < XW'(r_count);
    assign is_full    = XW'(r_count) >= XW'(DEPTH);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (kind_in)
                        KIND_READ:       n_state = in_range ? S_READ : S_IDLE;
                        KIND_DROP_FRONT,
                        KIND_DUMP:       n_state = (r_count != '0) ? S_STREAM : S_IDLE;
                        KIND_SORT:       n_state = (r_count > CW'(1)) ? S_STREAM : S_IDLE;
                        default:         n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: n_state = S_IDLE;
            S_STREAM: begin
                if (stream_end && !(r_op == KIND_SORT && r_swapped)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_op      = r_op;
        n_count   = r_count;
        n_rp      = r_rp;
        n_rv      = 1'b0;
        n_ra      = r_ra;
        n_carry   = r_carry;
        n_swapped = r_swapped;
        n_valid   = 1'b0;
        n_res     = r_res;
        o_we      = 1'b0;
        o_waddr   = '0;
        o_wdata   = i_req.value;
        o_raddr   = AW'(r_rp);
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op          = kind_in;
                    n_valid       = 1'b1;
                    n_res.element = '0;
                    n_res.status  = ST_OK;
                    n_res.last    = 1'b1;
                    case (kind_in)
                        KIND_APPEND: begin
                            if (is_full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = AW'(r_count);
                                n_count = r_count + CW'(1);
                            end
                        end
                        KIND_DROP_BACK: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        KIND_DROP_FRONT: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_valid = 1'b0;
                                n_rp    = CW'(1);
                            end
                        end
                        KIND_SORT: begin
                            if (r_count > CW'(1)) begin
                                n_valid   = 1'b0;
                                n_rp      = '0;
                                n_swapped = 1'b0;
                            end
                        end
                        KIND_READ: begin
                            if (in_range) begin
                                n_valid = 1'b0;
                                o_raddr = AW'(i_req.position);
                            end else begin
                                n_res.status = ST_RANGE;
                            end
                        end
                        KIND_WRITE: begin
                            if (in_range) begin
                                o_we    = 1'b1;
                                o_waddr = AW'(i_req.position);
                            end else begin
                                n_res.status = ST_RANGE;
                            end
                        end
                        KIND_CLEAR: n_count = '0;
                        KIND_SET_LENGTH: begin
                            if (XW'(i_req.new_length) > XW'(DEPTH)) begin
                                n_res.status = ST_RANGE;
                            end else begin
                                n_count = CW'(i_req.new_length);
                            end
                        end
                        KIND_DUMP: begin
                            if (r_count != '0) begin
                                n_valid = 1'b0;
                                n_rp    = '0;
                            end
                        end
                        default: ;
                    endcase
                    n_res.length = 5'(n_count);
                end
            end
            S_READ: begin
                n_valid       = 1'b1;
                n_res.element = i_rdata;
                n_res.length  = 5'(r_count);
                n_res.status  = ST_OK;
                n_res.last    = 1'b1;
            end
            S_STREAM: begin
                // reads run one address ahead of the write-back
                if (issue) begin
                    n_rp = r_rp + CW'(1);
                    n_rv = 1'b1;
                    n_ra = AW'(r_rp);
                end
                if (r_rv) begin
                    case (r_op)
                        KIND_DROP_FRONT: begin
                            o_we    = 1'b1;
                            o_waddr = r_ra - AW'(1);
                            o_wdata = i_rdata;
                        end
                        KIND_DUMP: begin
                            n_valid       = 1'b1;
                            n_res.element = i_rdata;
                            n_res.length  = 5'(r_count);
                            n_res.status  = ST_OK;
                            n_res.last    = (CW'(r_ra) + CW'(1)) == r_count;
                        end
                        KIND_SORT: begin
                            // carry holds the largest seen so far in this pass
                            if (r_ra == '0) begin
                                n_carry = i_rdata;
                            end else if (r_carry > i_rdata) begin
                                o_we      = 1'b1;
                                o_waddr   = r_ra - AW'(1);
                                o_wdata   = i_rdata;
                                n_swapped = 1'b1;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = r_ra - AW'(1);
                                o_wdata = r_carry;
                                n_carry = i_rdata;
                            end
                        end
                        default: ;
                    endcase
                end
                if (stream_end) begin
                    case (r_op)
                        KIND_DROP_FRONT: begin
                            n_count       = r_count - CW'(1);
                            n_valid       = 1'b1;
                            n_res.element = '0;
                            n_res.length  = 5'(n_count);
                            n_res.status  = ST_OK;
                            n_res.last    = 1'b1;
                        end
                        KIND_SORT: begin
                            o_we    = 1'b1;
                            o_waddr = AW'(r_count - CW'(1));
                            o_wdata = r_carry;
                            if (r_swapped) begin
                                n_rp      = '0;
                                n_swapped = 1'b0;
                            end else begin
                                n_valid       = 1'b1;
                                n_res.element = '0;
                                n_res.length  = 5'(r_count);
                                n_res.status  = ST_OK;
                                n_res.last    = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rv    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rv    <= n_rv;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_rp      <= n_rp;
        r_ra      <= n_ra;
        r_carry   <= n_carry;
        r_swapped <= n_swapped;
        r_res     <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_valid;
    assign o_res    = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= XW'(DEPTH))
        else $error("length count beyond capacity");

    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_rv)
        else $error("read data pending while idle");

    a_partial_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_res.last) |-> (r_op == KIND_DUMP && r_state == S_STREAM))
        else $error("non-final result outside a dump");

    a_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !o_we)
        else $error("write during single read");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_valid && r_state == S_IDLE))
        else $error("read result missing");

endmodule

### hdl/sortable_array_deque_top.sv
// Results: an in-range read passes through S_READ before its result is registered;
//   every other single-result item, refused ones too, gives it in the cycle after
//   acceptance with busy kept low. Front removal and dump stream through the read port;
//   dump gives one result a cycle. Sort: up to length passes through the single read port,
//   then the result. Synchronous active-low reset clears length and control; contents
//   undefined until written. Receiver cannot stall the strobe.
module sortable_array_deque_top #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  sad_pkg::t_req i_req,
    output logic          busy,
    output logic          o_strobe,
    output sad_pkg::t_res o_res
);
    import sad_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic               we;
    logic [AW-1:0]      waddr;
    logic signed [31:0] wdata;
    logic [AW-1:0]      raddr;
    logic signed [31:0] rdata;

    sad_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_raddr  (raddr),
        .i_rdata  (rdata)
    );

    sad_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

### sim/sad_checker.sv
`timescale 1ns / 100ps

// Watches the request and result channels, keeps its own copy of the array
// and the length, and checks each result item against the oldest prediction.
module sad_checker #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  sad_pkg::t_req i_req,
    input  logic          i_strobe,
    input  sad_pkg::t_res i_res,
    output int            o_fail_count,
    output int            o_pending
);
    import sad_pkg::*;

    logic signed [31:0] arr_model [DEPTH];
    int unsigned        len_model = 0;
    t_res               expected_q [$];
    int                 fails = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fails++;
    endtask

    function automatic t_res make_res(input logic signed [31:0] elem, input t_status st,
                                      input logic is_last);
        t_res r;
        r.element = elem;
        r.length  = 5'(len_model);
        r.status  = st;
        r.last    = is_last;
        return r;
    endfunction

    // Applies one accepted item to the array copy and queues what it should give.
    function automatic void predict_item(input t_req r);
        t_status            st;
        logic signed [31:0] elem;
        logic signed [31:0] tmp;
        bit                 swapped;
        st   = ST_OK;
        elem = '0;
        case (r.kind)
            KIND_APPEND: begin
                if (len_model >= DEPTH) begin
                    st = ST_FULL;
                end else begin
                    arr_model[len_model] = r.value;
                    len_model++;
                end
            end
            KIND_DROP_BACK: begin
                if (len_model == 0) st = ST_EMPTY;
                else len_model--;
            end
            KIND_DROP_FRONT: begin
                if (len_model == 0) begin
                    st = ST_EMPTY;
                end else begin
                    for (int k = 1; k < len_model; k++) arr_model[k-1] = arr_model[k];
                    len_model--;
                end
            end
            KIND_SORT: begin
                do begin
                    swapped = 1'b0;
                    for (int k = 1; k < len_model; k++) begin
                        if (arr_model[k-1] > arr_model[k]) begin
                            tmp            = arr_model[k-1];
                            arr_model[k-1] = arr_model[k];
                            arr_model[k]   = tmp;
                            swapped        = 1'b1;
                        end
                    end
                end while (swapped);
            end
            KIND_READ: begin
                if (r.position >= len_model) st = ST_RANGE;
                else elem = arr_model[r.position];
            end
            KIND_WRITE: begin
                if (r.position >= len_model) st = ST_RANGE;
                else arr_model[r.position] = r.value;
            end
            KIND_CLEAR: len_model = 0;
            KIND_SET_LENGTH: begin
                if (r.new_length > DEPTH) st = ST_RANGE;
                else len_model = r.new_length;
            end
            KIND_DUMP: begin
                if (len_model != 0) begin
                    for (int k = 0; k < len_model; k++)
                        expected_q.insert(expected_q.size(),
                                          make_res(arr_model[k], ST_OK,
                                                   (k + 1 == len_model)));
                    return;
                end
            end
            default: ;
        endcase
        expected_q.insert(expected_q.size(), make_res(elem, st, 1'b1));
    endfunction

    task automatic check_result(input t_res got);
        t_res want;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result item with nothing expected (element %0d)",
                                      got.element));
            return;
        end
        want = expected_q[0];
        expected_q.delete(0);
        if (got.element !== want.element)
            report_mismatch($sformatf("element %0d, expected %0d", got.element, want.element));
        if (got.length !== want.length)
            report_mismatch($sformatf("length %0d, expected %0d", got.length, want.length));
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // results first: one landing on an accept edge belongs to an older item
            if (i_strobe) check_result(i_res);
            if (i_start && !i_busy) predict_item(i_req);
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fails;
    end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import sad_pkg::*;

    localparam int         DEPTH             = 16;
    localparam int         RANDOM_ITEMS      = 125;
    localparam logic [3:0] KIND_FIRST_UNUSED = 4'd9;
    localparam logic [3:0] KIND_LAST_UNUSED  = 4'd15;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_strobe;
    t_res o_res;
    int   fail_count;
    int   pending;

    // length and written flags as the stimulus sees them, so that no
    // never-written entry is ever read, dumped or sorted
    int unsigned stim_len = 0;
    bit          stim_written [DEPTH];

    sortable_array_deque_top #(.DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    sad_checker #(.DEPTH(DEPTH)) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_req       (i_req),
        .i_strobe    (o_strobe),
        .i_res       (o_res),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic t_req mk_req(input logic [3:0] kind, input logic signed [31:0] value,
                                    input logic [3:0] position, input logic [4:0] new_length);
        t_req r;
        r.kind       = kind;
        r.value      = value;
        r.position   = position;
        r.new_length = new_length;
        return r;
    endfunction

    // Turns a request that would touch an unwritten entry into a write that fills a hole.
    function automatic t_req legalise(input t_req r);
        t_req f;
        int   hole;
        f    = r;
        hole = -1;
        for (int k = 0; k < stim_len; k++)
            if (!stim_written[k] && hole < 0) hole = k;
        if (f.kind == KIND_READ && f.position < stim_len && !stim_written[f.position])
            f.kind = KIND_WRITE;
        if ((f.kind == KIND_SORT || f.kind == KIND_DUMP) && hole >= 0) begin
            f.kind     = KIND_WRITE;
            f.position = 4'(hole);
        end
        return f;
    endfunction

    function automatic void note_accepted(input t_req r);
        case (r.kind)
            KIND_APPEND: begin
                if (stim_len < DEPTH) begin
                    stim_written[stim_len] = 1'b1;
                    stim_len++;
                end
            end
            KIND_DROP_BACK: if (stim_len > 0) stim_len--;
            KIND_DROP_FRONT: begin
                if (stim_len > 0) begin
                    for (int k = 1; k < stim_len; k++) stim_written[k-1] = stim_written[k];
                    stim_len--;
                end
            end
            KIND_WRITE: if (r.position < stim_len) stim_written[r.position] = 1'b1;
            KIND_CLEAR: stim_len = 0;
            KIND_SET_LENGTH: if (r.new_length <= DEPTH) stim_len = r.new_length;
            default: ;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'(signed'($urandom_range(0, 6)) - 3);   // small, so ties turn up
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req random_item();
        t_req        r;
        int unsigned pick;
        logic [3:0]  kind;
        logic [3:0]  pos;
        logic [4:0]  nlen;
        pick = $urandom_range(0, 99);
        if (pick < 30)      kind = KIND_APPEND;
        else if (pick < 38) kind = KIND_DROP_BACK;
        else if (pick < 46) kind = KIND_DROP_FRONT;
        else if (pick < 54) kind = KIND_SORT;
        else if (pick < 66) kind = KIND_READ;
        else if (pick < 76) kind = KIND_WRITE;
        else if (pick < 79) kind = KIND_CLEAR;
        else if (pick < 86) kind = KIND_SET_LENGTH;
        else if (pick < 95) kind = KIND_DUMP;
        else                kind = 4'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_UNUSED));
        if (stim_len > 0 && $urandom_range(0, 3) != 0)
            pos = 4'($urandom_range(0, stim_len - 1));
        else
            pos = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 3) == 0) nlen = 5'($urandom_range(0, 31));
        else                           nlen = 5'($urandom_range(0, stim_len));
        r = mk_req(kind, pick_value(), pos, nlen);
        return r;
    endfunction

    task automatic send_item(input t_req r, input bit may_idle);
        t_req legal;
        legal = legalise(r);
        i_req <= legal;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        note_accepted(legal);
        if (may_idle && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty array corner cases
        send_item(mk_req(KIND_DROP_BACK, 0, 0, 0), 1'b1);
        send_item(mk_req(KIND_DROP_FRONT, 0, 0, 0), 1'b1);
        send_item(mk_req(KIND_DUMP, 0, 0, 0), 1'b1);
        send_item(mk_req(KIND_READ, 0, 0, 0), 1'b1);
        send_item(mk_req(KIND_WRITE, 7, 15, 0), 1'b1);
        // signed extremes through sort and dump
        send_item(mk_req(KIND_APPEND, 32'sh8000_0000, 0, 0), 1'b1);
        send_item(mk_req(KIND_APPEND, 32'sh7fff_ffff, 0, 0), 1'b1);
        send_item(mk_req(KIND_APPEND, -1, 0, 0), 1'b1);
        send_item(mk_req(KIND_APPEND, 0, 0, 0), 1'b1);
        send_item(mk_req(KIND_APPEND, 1, 0, 0), 1'b1);
        send_item(mk_req(KIND_SORT, 0, 0, 0), 1'b0);
        send_item(mk_req(KIND_DUMP, 0, 0, 0), 1'b0);
        send_item(mk_req(KIND_READ, 0, 4, 0), 1'b1);
        send_item(mk_req(KIND_READ, 0, 5, 0), 1'b1);
        send_item(mk_req(KIND_WRITE, 32'sh7fff_ffff, 0, 0), 1'b1);
        send_item(mk_req(KIND_DROP_FRONT, 0, 0, 0), 1'b1);
        send_item(mk_req(KIND_DROP_BACK, 0, 0, 0), 1'b1);
        send_item(mk_req(KIND_SET_LENGTH, 0, 0, 5'd17), 1'b1);
        send_item(mk_req(KIND_SET_LENGTH, 0, 0, 5'd31), 1'b1);
        send_item(mk_req(KIND_SET_LENGTH, 0, 0, 5'd16), 1'b1);
        send_item(mk_req(KIND_APPEND, 5, 0, 0), 1'b1);
        send_item(mk_req(KIND_FIRST_UNUSED, 0, 0, 0), 1'b1);
        send_item(mk_req(KIND_LAST_UNUSED, -1, 4'hf, 5'h1f), 1'b1);
        send_item(mk_req(KIND_CLEAR, 0, 0, 0), 1'b1);
        send_item(mk_req(KIND_SET_LENGTH, 0, 0, 5'd0), 1'b1);

        // a stretch in the middle and the tail run back to back
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_item(random_item(), n < RANDOM_ITEMS - 30 && !(n >= 50 && n < 75));
        start <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
